// File: hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the fixed-size chunk allocator.
package fba_pkg;

   // Default number of chunks tracked by the used-bit store
   localparam int POOL_DEPTH_DEF = 256;

   // Configuration register widths and reset values
   localparam int CNT_W   = 9;
   localparam int BYTES_W = 16;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST = 9'd256;
   localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = 16'd64;

   // Register select, taken from paddr[2]
   localparam logic REG_CHUNK_COUNT = 1'b0;
   localparam logic REG_CHUNK_BYTES = 1'b1;

   // Request operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] RSP_OK        = 2'd0;
   localparam logic [1:0] RSP_NO_FREE   = 2'd1;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic       func;
      logic [7:0] chunk_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_index;
      logic [23:0] byte_offset;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;
      logic capture;
      logic exec;
      logic scan;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_done;
      logic need_scan;
      logic scan_stop;
   } sts_type;

endpackage

// File: hw/rtl/fba_datapath.sv
`timescale 1ns / 1ps
// Datapath: used-bit memory, free and used marks, scan pointer and result register.
module fba_datapath
   import fba_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  req_type            req_data,
   input  logic [CNT_W-1:0]   chunk_count,
   input  logic [BYTES_W-1:0] chunk_bytes,
   output rsp_type            rsp_data
);

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int MW = $clog2(POOL_DEPTH + 1);
   localparam int CW = (MW > CNT_W) ? MW : CNT_W;
   localparam int PW = MW + BYTES_W;

   localparam logic [MW-1:0] NUM_M    = MW'(POOL_DEPTH);
   localparam logic [AW-1:0] CLR_LAST = AW'(POOL_DEPTH - 1);

   logic          used_mem [POOL_DEPTH];
   logic          rd_bit_ff;

   req_type       req_ff;
   rsp_type       rsp_ff,  rsp_in;
   logic [MW-1:0] lf_ff,   lf_in;
   logic [MW-1:0] lu_ff,   lu_in;
   logic [MW-1:0] ptr_ff,  ptr_in;
   logic [AW-1:0] clr_ff,  clr_in;

   logic          we;
   logic [AW-1:0] wa;
   logic          wd;

   logic [CW-1:0] eff_count;
   logic [CW-1:0] idx_c, lf_c, lu_c, ptr_c;
   logic          is_alloc, no_free, bad_free, hit_lu, scan_stop, need_scan;
   logic [PW-1:0] product;

   // Saturate the programmed count at the store depth
   assign eff_count = (CW'(chunk_count) > CW'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                           : CW'(chunk_count);

   assign idx_c = CW'(req_ff.chunk_index);
   assign lf_c  = CW'(lf_ff);
   assign lu_c  = CW'(lu_ff);
   assign ptr_c = CW'(ptr_ff);

   assign is_alloc = (req_ff.func == FUNC_ALLOC);
   assign no_free  = (lf_c >= eff_count);
   assign bad_free = (idx_c < lu_c) || (idx_c >= eff_count);
   assign hit_lu   = (idx_c == lu_c);

   assign need_scan = is_alloc ? !no_free : (!bad_free && hit_lu);
   // Allocate scans for a clear bit, free scans for a set bit
   assign scan_stop = (ptr_c >= eff_count) || (rd_bit_ff != is_alloc);

   assign product = PW'(lf_ff) * PW'(chunk_bytes);

   always_comb begin
      ptr_in = ptr_ff;
      lf_in  = lf_ff;
      lu_in  = lu_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      we     = 1'b0;
      wa     = clr_ff;
      wd     = 1'b0;

      if (cmd.clr_step) begin
         we     = 1'b1;
         clr_in = clr_ff + AW'(1);
      end

      if (cmd.exec) begin
         rsp_in.status        = RSP_OK;
         rsp_in.granted_index = '0;
         rsp_in.byte_offset   = '0;
         if (is_alloc) begin
            if (no_free) begin
               rsp_in.status = RSP_NO_FREE;
            end else begin
               we    = 1'b1;
               wa    = AW'(lf_ff);
               wd    = 1'b1;
               lu_in = (lf_ff < lu_ff) ? lf_ff : lu_ff;
               ptr_in = lf_ff + MW'(1);
               rsp_in.granted_index = 8'(lf_ff);
               rsp_in.byte_offset   = 24'(product);
            end
         end else begin
            if (bad_free) begin
               rsp_in.status = RSP_NOT_FOUND;
            end else begin
               we     = 1'b1;
               wa     = AW'(req_ff.chunk_index);
               wd     = 1'b0;
               lf_in  = (idx_c < lf_c) ? MW'(req_ff.chunk_index) : lf_ff;
               ptr_in = MW'(req_ff.chunk_index) + MW'(1);
            end
         end
      end

      if (cmd.scan) begin
         if (scan_stop) begin
            if (is_alloc) begin
               lf_in = ptr_ff;
            end else begin
               lu_in = ptr_ff;
            end
         end else begin
            ptr_in = ptr_ff + MW'(1);
         end
      end
   end

   // Read ahead at the next pointer so each scan cycle checks one bit
   always_ff @(posedge clock) begin
      if (we) begin
         used_mem[wa] <= wd;
      end
      rd_bit_ff <= used_mem[AW'(ptr_in)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_ff  <= '0;
         lu_ff  <= NUM_M;
         clr_ff <= '0;
      end else begin
         lf_ff  <= lf_in;
         lu_ff  <= lu_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   assign sts.clr_done  = (clr_ff == CLR_LAST);
   assign sts.need_scan = need_scan;
   assign sts.scan_stop = scan_stop;
   assign rsp_data      = rsp_ff;

endmodule

// File: hw/rtl/fba_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: clearing pass, request execution and scan sequencing.
module fba_ctrl
   import fba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_scan) begin
               state_in = S_SCAN;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_stop) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/fixed_block_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed-size chunk allocator: register port, controller and datapath.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start and not busy
//   result    rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//   config    psel, penable, pwrite, paddr,  write on psel & penable & pwrite,
//             pwdata, prdata, pready         pready tied high
//
// After reset the used-bit memory is cleared one entry a cycle, with busy high.
// A request with no scan needed passes only the capture and execute states; else the scan
// steps one used-bit entry per cycle, a rate set by the single memory read port.
// busy stays high until the result strobe; a new transaction may start in the strobe cycle.
// The result receiver cannot stall: each result is flagged by rsp_valid for exactly one cycle.
module fixed_block_allocator_unit
   import fba_pkg::*;
#(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   logic [CNT_W-1:0]   chunk_count_ff,  chunk_count_in;
   logic [BYTES_W-1:0] chunk_bytes_ff,  chunk_bytes_in;
   logic               csr_write;
   cmd_type            cmd;
   sts_type            sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      chunk_count_in = chunk_count_ff;
      chunk_bytes_in = chunk_bytes_ff;
      prdata         = '0;
      unique case (paddr[2])
         REG_CHUNK_COUNT: begin
            prdata = PDATA_W'(chunk_count_ff);
            if (csr_write) begin
               chunk_count_in = pwdata[CNT_W-1:0];
            end
         end
         REG_CHUNK_BYTES: begin
            prdata = PDATA_W'(chunk_bytes_ff);
            if (csr_write) begin
               chunk_bytes_in = pwdata[BYTES_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= CHUNK_COUNT_RST;
         chunk_bytes_ff <= CHUNK_BYTES_RST;
      end else begin
         chunk_count_ff <= chunk_count_in;
         chunk_bytes_ff <= chunk_bytes_in;
      end
   end

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   fba_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .chunk_count (chunk_count_ff),
      .chunk_bytes (chunk_bytes_ff),
      .rsp_data    (rsp_data)
   );

   // A result only follows a transaction in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   // An accepted transaction holds the block busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a transaction");

   // Failed results carry no grant
   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != RSP_OK) |->
         (rsp_data.granted_index == '0 && rsp_data.byte_offset == '0))
      else $error("grant fields set on a failed result");

endmodule
